// File: src/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg: shared constants for the ramped rotate-to-angle controller
// Angle format, field widths, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rra_pkg;

  // Angle format: signed fixed point, fraction bits per degree
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ONE_DEG   = 1 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN = 360 * ONE_DEG;
  localparam int HALF_TURN = 180 * ONE_DEG;

  // Field widths
  localparam int OP_W    = 2;
  localparam int GYRO_W  = 24;
  localparam int ROT_W   = 21;
  localparam int HEAD_W  = 25;
  localparam int SPEED_W = 15;
  localparam int WIN_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 16;

  // Largest number of whole turns in a rotation request
  localparam int MAX_TURNS = (1 << (ROT_W - 1)) / FULL_TURN;

  // Opcodes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMPDOWN_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_GAIN       = 3'd4;

  // Register reset values
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST       = 15'd3277;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST       = 15'd16384;
  localparam logic [SPEED_W-1:0] RAMP_UP_STEP_RST    = 15'd328;
  localparam logic [WIN_W-1:0]   RAMPDOWN_WINDOW_RST = 16'd7680;
  localparam logic [GAIN_W-1:0]  SLOW_GAIN_RST       = 16'd256;

endpackage

// File: src/rra_channels.sv
// ----------------------------------------------------------------------------
// rra channels: valid/ready interfaces for commands, results and config
// Each interface has a source and a sink modport.
// ----------------------------------------------------------------------------

interface rra_cmd_if
  import rra_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [GYRO_W-1:0] gyro_angle;
  logic signed [ROT_W-1:0]  rotation_request;

  modport source (output valid, output opcode, output gyro_angle,
                  output rotation_request, input ready);
  modport sink   (input valid, input opcode, input gyro_angle,
                  input rotation_request, output ready);
endinterface

interface rra_res_if
  import rra_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      finished;

  modport source (output valid, output left_drive, output right_drive,
                  output finished, input ready);
  modport sink   (input valid, input left_drive, input right_drive,
                  input finished, output ready);
endinterface

interface rra_cfg_if
  import rra_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/ramped_rotate_to_angle.sv
// ----------------------------------------------------------------------------
// ramped_rotate_to_angle: ramped rotate-by-angle speed controller
// Start sets target heading, direction and speed; each tick ramps the speed,
// clamps it and drives the two sides in opposite directions.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  cmd     | in  | valid / ready | opcode, gyro_angle, rotation_request
//  result  | out | valid / ready | left_drive, right_drive, finished
//  cfg     | in  | valid / ready | index, data (always ready)
//
//  One item per cycle sustained while the result is taken; each item gives
//  one result, passing through the input register, one pass of logic and
//  the result register.
//  The pass holds one 16x16 multiply, the speed clamps and the turn fold.
//  Reset (rst, synchronous) empties both registers and restores the state
//  and registers to their reset values.
//  A stalled result holds in the result register while the next item
//  waits in the input register; cmd.ready drops only when both are full.
//
module ramped_rotate_to_angle
  import rra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  rra_cmd_if.sink  cmd,
  rra_res_if.source result,
  rra_cfg_if.sink  cfg
);

  localparam logic signed [ROT_W:0] FULL_S = (ROT_W+1)'(FULL_TURN);
  localparam logic signed [ROT_W:0] HALF_S = (ROT_W+1)'(HALF_TURN);

  // Configuration registers
  logic [SPEED_W-1:0] min_speed;
  logic [SPEED_W-1:0] max_speed;
  logic [SPEED_W-1:0] ramp_up_step;
  logic [WIN_W-1:0]   rampdown_window;
  logic [GAIN_W-1:0]  slow_gain;

  // Controller state
  logic signed [HEAD_W-1:0] target_heading;
  logic [SPEED_W-1:0]       drive_speed;
  logic                     turning_right;
  logic                     near_target_seen;

  // Input register
  logic                     s1_valid;
  logic [OP_W-1:0]          s1_op;
  logic signed [GYRO_W-1:0] s1_gyro;
  logic signed [ROT_W-1:0]  s1_rot;

  // Result register
  logic                      o_valid;
  logic signed [DRIVE_W-1:0] o_left;
  logic signed [DRIVE_W-1:0] o_right;
  logic                      o_fin;

  logic s1_adv;

  // Next values from one item
  logic signed [HEAD_W-1:0]  target_heading_next;
  logic [SPEED_W-1:0]        drive_speed_next;
  logic                      turning_right_next;
  logic                      near_target_seen_next;
  logic signed [DRIVE_W-1:0] left_next;
  logic signed [DRIVE_W-1:0] right_next;
  logic                      fin_next;

  // Start path signals
  logic                     rot_neg;
  logic [ROT_W-1:0]         rot_abs;
  logic [ROT_W-1:0]         rot_rem;
  logic signed [ROT_W:0]    rot_red;
  logic signed [ROT_W:0]    rot_wrap;

  // Tick path signals
  logic signed [HEAD_W:0]       diff;
  logic [HEAD_W:0]              remaining;
  logic                         in_window;
  logic [WIN_W-1:0]             depth;
  logic [WIN_W+GAIN_W-1:0]      prod;
  logic signed [SPEED_W+2:0]    speed_raw;
  logic signed [SPEED_W+2:0]    speed_lo;
  logic [SPEED_W-1:0]           speed_new;
  logic                         near_met;
  logic signed [DRIVE_W-1:0]    drive_pos;

  assign s1_adv      = s1_valid && (!o_valid || result.ready);
  assign cmd.ready   = !s1_valid || s1_adv;
  assign cfg.ready   = 1'b1;

  assign result.valid       = o_valid;
  assign result.left_drive  = o_left;
  assign result.right_drive = o_right;
  assign result.finished    = o_fin;

  // Reduce the rotation to one turn and fold it into a half turn each way
  always_comb begin
    rot_neg = s1_rot[ROT_W-1];
    rot_abs = rot_neg ? ROT_W'(-s1_rot) : ROT_W'(s1_rot);
    rot_rem = rot_abs;
    for (int k = 1; k <= MAX_TURNS; k++) begin
      if (32'(rot_abs) >= 32'(k * FULL_TURN)) begin
        rot_rem = ROT_W'(32'(rot_abs) - 32'(k * FULL_TURN));
      end
    end
    rot_red = rot_neg ? -$signed({1'b0, rot_rem}) : $signed({1'b0, rot_rem});
    if (rot_red < -HALF_S) begin
      rot_wrap = rot_red + FULL_S;
    end else if (rot_red > HALF_S) begin
      rot_wrap = rot_red - FULL_S;
    end else begin
      rot_wrap = rot_red;
    end
  end

  // Ramp, slow down and clamp the speed on a tick
  always_comb begin
    diff      = (HEAD_W+1)'(target_heading) - (HEAD_W+1)'(s1_gyro);
    remaining = (diff < 0) ? (HEAD_W+1)'(-diff) : (HEAD_W+1)'(diff);
    in_window = remaining < (HEAD_W+1)'(rampdown_window);
    depth     = rampdown_window - remaining[WIN_W-1:0];
    prod      = depth * slow_gain;
    if (in_window) begin
      speed_raw = $signed({3'b0, drive_speed})
                - $signed({2'b0, prod[WIN_W+GAIN_W-1:GAIN_W]});
    end else if (drive_speed < max_speed) begin
      speed_raw = $signed({3'b0, drive_speed}) + $signed({3'b0, ramp_up_step});
    end else begin
      speed_raw = $signed({3'b0, max_speed});
    end
    // min clamp first, then max on the full-width value
    if (speed_raw < $signed({3'b0, min_speed})) begin
      speed_lo = $signed({3'b0, min_speed});
    end else begin
      speed_lo = speed_raw;
    end
    if (speed_lo > $signed({3'b0, max_speed})) begin
      speed_new = max_speed;
    end else begin
      speed_new = speed_lo[SPEED_W-1:0];
    end
    near_met  = remaining < (HEAD_W+1)'(ONE_DEG);
    drive_pos = $signed({1'b0, speed_new});
  end

  // Decode the opcode into state and result updates
  always_comb begin
    target_heading_next   = target_heading;
    drive_speed_next      = drive_speed;
    turning_right_next    = turning_right;
    near_target_seen_next = near_target_seen;
    left_next             = '0;
    right_next            = '0;
    fin_next              = 1'b0;
    unique case (s1_op)
      OP_START: begin
        target_heading_next   = HEAD_W'(s1_gyro) + HEAD_W'(rot_wrap);
        turning_right_next    = rot_wrap < 0;
        drive_speed_next      = min_speed;
        near_target_seen_next = 1'b0;
      end
      OP_TICK: begin
        drive_speed_next = speed_new;
        // flip direction on overshoot
        turning_right_next = turning_right ? (diff <= 0) : (diff < 0);
        fin_next              = near_met && near_target_seen;
        near_target_seen_next = near_target_seen || near_met;
        if (turning_right_next) begin
          left_next  = -drive_pos;
          right_next = drive_pos;
        end else begin
          left_next  = drive_pos;
          right_next = -drive_pos;
        end
      end
      default: begin
        // end command and unused code: zero drive, state held
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed       <= MIN_SPEED_RST;
      max_speed       <= MAX_SPEED_RST;
      ramp_up_step    <= RAMP_UP_STEP_RST;
      rampdown_window <= RAMPDOWN_WINDOW_RST;
      slow_gain       <= SLOW_GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MIN_SPEED:       min_speed       <= cfg.data[SPEED_W-1:0];
        REG_MAX_SPEED:       max_speed       <= cfg.data[SPEED_W-1:0];
        REG_RAMP_UP_STEP:    ramp_up_step    <= cfg.data[SPEED_W-1:0];
        REG_RAMPDOWN_WINDOW: rampdown_window <= cfg.data[WIN_W-1:0];
        REG_SLOW_GAIN:       slow_gain       <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller state and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading   <= '0;
      drive_speed      <= '0;
      turning_right    <= 1'b0;
      near_target_seen <= 1'b0;
      s1_valid         <= 1'b0;
      o_valid          <= 1'b0;
    end else begin
      if (s1_adv) begin
        target_heading   <= target_heading_next;
        drive_speed      <= drive_speed_next;
        turning_right    <= turning_right_next;
        near_target_seen <= near_target_seen_next;
      end
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Capture the item and load the result
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op   <= cmd.opcode;
      s1_gyro <= cmd.gyro_angle;
      s1_rot  <= cmd.rotation_request;
    end
    if (s1_adv) begin
      o_left  <= left_next;
      o_right <= right_next;
      o_fin   <= fin_next;
    end
  end

endmodule

// File: src/rra_checker.sv
// ----------------------------------------------------------------------------
// rra_checker: port-level checks for the rotate-to-angle controller
// Watches the command and result channels; attached by bind.
// ----------------------------------------------------------------------------
module rra_checker
  import rra_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic signed [DRIVE_W-1:0] left_drive,
  input logic signed [DRIVE_W-1:0] right_drive
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Empty the result register on reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // An item taken with the output empty shows a result once it has passed the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !res_valid |=> ##1 res_valid)
    else $error("result missing after accepted item");

  // Drive the two sides in opposite directions
  a_opposite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (left_drive == -right_drive) && (left_drive != 16'sh8000))
    else $error("left and right drive not opposite");

endmodule

bind ramped_rotate_to_angle rra_checker u_rra_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .left_drive  (result.left_drive),
  .right_drive (result.right_drive)
);
